[hw/rtl/axcp_pkg.sv]
// axcp_pkg: shared types and constants of the cascaded pid axis controller
// no dependencies; used by every module of the block
`default_nettype none

package axcp_pkg;

  localparam int GAIN_BITS     = 16;
  localparam int LIMIT_BITS    = 23;
  localparam int LOAD_BITS     = 24;
  localparam int DRIVE_BITS    = 32;
  localparam int REQ_BITS      = 2;
  localparam int REG_ADDR_BITS = 3;

  // request codes
  localparam logic [REQ_BITS-1:0] REQ_ANGLE = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_RATE  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd2;

  // register indexes
  localparam logic [REG_ADDR_BITS-1:0] REG_ANGLE_KP = 3'd0;
  localparam logic [REG_ADDR_BITS-1:0] REG_ANGLE_KI = 3'd1;
  localparam logic [REG_ADDR_BITS-1:0] REG_ANGLE_KD = 3'd2;
  localparam logic [REG_ADDR_BITS-1:0] REG_RATE_KP  = 3'd3;
  localparam logic [REG_ADDR_BITS-1:0] REG_RATE_KI  = 3'd4;
  localparam logic [REG_ADDR_BITS-1:0] REG_RATE_KD  = 3'd5;
  localparam logic [REG_ADDR_BITS-1:0] REG_LIMIT    = 3'd6;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 23'd1920;

  typedef struct packed {
    logic signed [GAIN_BITS-1:0] angle_kp;
    logic signed [GAIN_BITS-1:0] angle_ki;
    logic signed [GAIN_BITS-1:0] angle_kd;
    logic signed [GAIN_BITS-1:0] rate_kp;
    logic signed [GAIN_BITS-1:0] rate_ki;
    logic signed [GAIN_BITS-1:0] rate_kd;
  } axcp_gains_t;

  // result flags, loop_kind in the lowest bit
  typedef struct packed {
    logic clamped;
    logic loop_kind;
  } axcp_flags_t;

endpackage

`default_nettype wire

[hw/rtl/axcp_regs.sv]
// axcp_regs: gain and integral limit configuration registers
// depends on axcp_pkg
`default_nettype none

module axcp_regs (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [axcp_pkg::REG_ADDR_BITS-1:0]    cfg_addr_i,
  input  wire logic [axcp_pkg::LIMIT_BITS-1:0]       cfg_data_i,
  output axcp_pkg::axcp_gains_t                      gains_o,
  output logic [axcp_pkg::LIMIT_BITS-1:0]            limit_o
);

  axcp_pkg::axcp_gains_t                 gains_q;
  logic [axcp_pkg::LIMIT_BITS-1:0]       limit_q;
  logic signed [axcp_pkg::GAIN_BITS-1:0] gain_wr;

  assign gain_wr = $signed(cfg_data_i[axcp_pkg::GAIN_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
      limit_q <= axcp_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        axcp_pkg::REG_ANGLE_KP: gains_q.angle_kp <= gain_wr;
        axcp_pkg::REG_ANGLE_KI: gains_q.angle_ki <= gain_wr;
        axcp_pkg::REG_ANGLE_KD: gains_q.angle_kd <= gain_wr;
        axcp_pkg::REG_RATE_KP:  gains_q.rate_kp  <= gain_wr;
        axcp_pkg::REG_RATE_KI:  gains_q.rate_ki  <= gain_wr;
        axcp_pkg::REG_RATE_KD:  gains_q.rate_kd  <= gain_wr;
        axcp_pkg::REG_LIMIT:    limit_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign gains_o = gains_q;
  assign limit_o = limit_q;

endmodule

`default_nettype wire

[hw/rtl/axcp_state.sv]
// axcp_state: input register, error forming, integral update with clamp,
// loop state and the operand register feeding the multipliers; uses axcp_pkg
`default_nettype none

module axcp_state #(
  parameter int SIGNAL_BITS   = 16,
  parameter int INTEGRAL_BITS = 24
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [axcp_pkg::REQ_BITS-1:0]         req_type_i,
  input  wire logic signed [SIGNAL_BITS-1:0]         setpoint_i,
  input  wire logic signed [SIGNAL_BITS-1:0]         measured_value_i,
  input  wire logic signed [SIGNAL_BITS-1:0]         gyro_rate_i,
  input  wire logic signed [axcp_pkg::LOAD_BITS-1:0] integral_load_i,
  input  wire axcp_pkg::axcp_gains_t                 gains_i,
  input  wire logic [axcp_pkg::LIMIT_BITS-1:0]       limit_i,
  input  wire logic                                  down_ready_i,
  output logic                                       op_valid_o,
  output logic signed [axcp_pkg::GAIN_BITS-1:0]      gain_p_o,
  output logic signed [axcp_pkg::GAIN_BITS-1:0]      gain_i_o,
  output logic signed [axcp_pkg::GAIN_BITS-1:0]      gain_d_o,
  output logic signed [SIGNAL_BITS:0]                op_p_o,
  output logic signed [INTEGRAL_BITS-1:0]            op_i_o,
  output logic signed [SIGNAL_BITS+1:0]              op_d_o,
  output axcp_pkg::axcp_flags_t                      flags_o
);

  localparam int EW = SIGNAL_BITS + 1;
  localparam int DW = SIGNAL_BITS + 2;
  localparam int IB = INTEGRAL_BITS;
  localparam int SW = ((IB > EW) ? IB : EW) + 1;
  localparam int CW = (SW > axcp_pkg::LOAD_BITS + 1) ? SW : axcp_pkg::LOAD_BITS + 1;

  // input stage
  logic                                  v1_q;
  logic [axcp_pkg::REQ_BITS-1:0]         kind1_q;
  logic signed [SIGNAL_BITS-1:0]         sp1_q, meas1_q, gyro1_q;
  logic signed [axcp_pkg::LOAD_BITS-1:0] ld1_q;

  // loop state
  logic signed [IB-1:0] ang_int_q, rate_int_q;
  logic signed [EW-1:0] prev_err_q;

  // operand stage
  logic                                  v2_q;
  logic signed [axcp_pkg::GAIN_BITS-1:0] gp_q, gi_q, gd_q;
  logic signed [EW-1:0]                  op_p_q;
  logic signed [IB-1:0]                  op_i_q;
  logic signed [DW-1:0]                  op_d_q;
  axcp_pkg::axcp_flags_t                 flags_q;

  logic en1, en2, fire1, fire2, is_rate, is_step;
  logic signed [EW-1:0] err_a, err_r, err_sel;
  logic signed [DW-1:0] d_r;
  logic signed [IB-1:0] acc_sel, new_int, ld_sat;
  logic signed [CW-1:0] sum_c, lim_c, imax_c, imin_c, lim_eff, int_c, ld_c, lds_c;
  logic                 hit;

  assign en2        = !v2_q || down_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign fire1      = in_valid_i && en1;
  assign fire2      = v1_q && en2;
  assign is_rate    = (kind1_q == axcp_pkg::REQ_RATE);
  assign is_step    = (kind1_q == axcp_pkg::REQ_ANGLE) || is_rate;

  always_comb begin
    err_a   = EW'(meas1_q) - EW'(sp1_q);
    err_r   = EW'(gyro1_q) - EW'(sp1_q);
    d_r     = DW'(err_r) - DW'(prev_err_q);
    err_sel = is_rate ? err_r : err_a;
    acc_sel = is_rate ? rate_int_q : ang_int_q;

    imax_c  = $signed({{(CW-IB+1){1'b0}}, {(IB-1){1'b1}}});
    imin_c  = $signed({{(CW-IB+1){1'b1}}, {(IB-1){1'b0}}});
    lim_c   = $signed({{(CW-axcp_pkg::LIMIT_BITS){1'b0}}, limit_i});
    lim_eff = (lim_c > imax_c) ? imax_c : lim_c;

    sum_c = CW'(acc_sel) + CW'(err_sel);
    hit   = (sum_c > lim_eff);
    if (hit) begin
      int_c = lim_eff;
    end else if (sum_c < imin_c) begin
      int_c = imin_c;
    end else begin
      int_c = sum_c;
    end
    new_int = int_c[IB-1:0];

    ld_c = CW'(ld1_q);
    if (ld_c > imax_c) begin
      lds_c = imax_c;
    end else if (ld_c < imin_c) begin
      lds_c = imin_c;
    end else begin
      lds_c = ld_c;
    end
    ld_sat = lds_c[IB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      ang_int_q  <= '0;
      rate_int_q <= '0;
      prev_err_q <= '0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q && is_step;
      end
      if (fire2) begin
        case (kind1_q)
          axcp_pkg::REQ_ANGLE: ang_int_q <= new_int;
          axcp_pkg::REQ_RATE: begin
            rate_int_q <= new_int;
            prev_err_q <= err_r;
          end
          axcp_pkg::REQ_LOAD:  ang_int_q <= ld_sat;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      kind1_q <= req_type_i;
      sp1_q   <= setpoint_i;
      meas1_q <= measured_value_i;
      gyro1_q <= gyro_rate_i;
      ld1_q   <= integral_load_i;
    end
    if (fire2) begin
      gp_q              <= is_rate ? gains_i.rate_kp : gains_i.angle_kp;
      gi_q              <= is_rate ? gains_i.rate_ki : gains_i.angle_ki;
      gd_q              <= is_rate ? gains_i.rate_kd : gains_i.angle_kd;
      op_p_q            <= err_sel;
      op_i_q            <= new_int;
      op_d_q            <= is_rate ? d_r : DW'(gyro1_q);
      flags_q.loop_kind <= is_rate;
      flags_q.clamped   <= hit;
    end
  end

  assign op_valid_o = v2_q;
  assign gain_p_o   = gp_q;
  assign gain_i_o   = gi_q;
  assign gain_d_o   = gd_q;
  assign op_p_o     = op_p_q;
  assign op_i_o     = op_i_q;
  assign op_d_o     = op_d_q;
  assign flags_o    = flags_q;

  // a load or unused request never reaches the multipliers
  a_no_result_for_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire2 && !is_step) |=> !v2_q)
    else $error("non-step request produced an operand beat");

  // a rate step leaves its error as the previous rate error
  a_prev_err_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire2 && is_rate) |=> (prev_err_q == op_p_q))
    else $error("previous rate error not updated");

endmodule

`default_nettype wire

[hw/rtl/axcp_mac.sv]
// axcp_mac: gain products, signed sum and 32-bit saturation into the
// output register; depends on axcp_pkg
`default_nettype none

module axcp_mac #(
  parameter int SIGNAL_BITS   = 16,
  parameter int INTEGRAL_BITS = 24
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  op_valid_i,
  output logic                                       op_ready_o,
  input  wire logic signed [axcp_pkg::GAIN_BITS-1:0] gain_p_i,
  input  wire logic signed [axcp_pkg::GAIN_BITS-1:0] gain_i_i,
  input  wire logic signed [axcp_pkg::GAIN_BITS-1:0] gain_d_i,
  input  wire logic signed [SIGNAL_BITS:0]           op_p_i,
  input  wire logic signed [INTEGRAL_BITS-1:0]       op_i_i,
  input  wire logic signed [SIGNAL_BITS+1:0]         op_d_i,
  input  wire axcp_pkg::axcp_flags_t                 flags_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [axcp_pkg::DRIVE_BITS-1:0]     drive_o,
  output axcp_pkg::axcp_flags_t                      flags_o
);

  localparam int GB  = axcp_pkg::GAIN_BITS;
  localparam int OB  = axcp_pkg::DRIVE_BITS;
  localparam int PPW = GB + SIGNAL_BITS + 1;
  localparam int PIW = GB + INTEGRAL_BITS;
  localparam int PDW = GB + SIGNAL_BITS + 2;
  localparam int AW  = ((PDW > PIW) ? PDW : PIW) + 2;

  logic                   v3_q, vo_q;
  logic signed [PPW-1:0]  prod_p_q;
  logic signed [PIW-1:0]  prod_i_q;
  logic signed [PDW-1:0]  prod_d_q;
  axcp_pkg::axcp_flags_t  flags3_q, flags_out_q;
  logic signed [OB-1:0]   drive_q;

  logic                   en_out, en3;
  logic signed [AW-1:0]   sum, max_c, min_c, sat;

  assign en_out     = !vo_q || out_ready_i;
  assign en3        = !v3_q || en_out;
  assign op_ready_o = en3;

  always_comb begin
    max_c = $signed({{(AW-OB+1){1'b0}}, {(OB-1){1'b1}}});
    min_c = $signed({{(AW-OB+1){1'b1}}, {(OB-1){1'b0}}});
    sum   = AW'(prod_p_q) - AW'(prod_i_q) + AW'(prod_d_q);
    if (sum > max_c) begin
      sat = max_c;
    end else if (sum < min_c) begin
      sat = min_c;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= op_valid_i;
      end
      if (en_out) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i && en3) begin
      prod_p_q <= PPW'(gain_p_i) * PPW'(op_p_i);
      prod_i_q <= PIW'(gain_i_i) * PIW'(op_i_i);
      prod_d_q <= PDW'(gain_d_i) * PDW'(op_d_i);
      flags3_q <= flags_i;
    end
    if (v3_q && en_out) begin
      drive_q     <= sat[OB-1:0];
      flags_out_q <= flags3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign drive_o     = drive_q;
  assign flags_o     = flags_out_q;

  // a product beat moving on always lands in the output register
  a_products_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en_out) |=> vo_q)
    else $error("product beat lost");

  // the pipeline only stalls behind a full output register
  a_stall_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op_ready_o |-> (vo_q && !out_ready_i))
    else $error("product stage stalled with output free");

endmodule

`default_nettype wire

[hw/rtl/axis_cascade_pid.sv]
// axis_cascade_pid: top level of one axis of the angle/rate pid controller
// instantiates axcp_regs, axcp_state and axcp_mac; depends on axcp_pkg
//
// Takes one input beat per clock unless the output stalls; each accepted angle
// step (req_type 0) or rate step (1) gives one registered result beat; a load
// step (2) only writes the angle integral and an unused type is dropped, both
// without a result beat. The rate is kept by the combinational add-and-clamp
// of each integral; the three gain products sit in their own register stage
// ahead of the sum and 32-bit saturation. Integrals clamp above at
// integral_limit and saturate below at the accumulator range.
`default_nettype none

module axis_cascade_pid #(
  parameter int SIGNAL_BITS   = 16,
  parameter int INTEGRAL_BITS = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [axcp_pkg::REG_ADDR_BITS-1:0] cfg_addr_i,
  input  wire logic [axcp_pkg::LIMIT_BITS-1:0]    cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // setpoint, measured_value, gyro_rate, integral_load, zero fill
  input  wire logic [((3*SIGNAL_BITS+axcp_pkg::LOAD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  wire logic [axcp_pkg::REQ_BITS-1:0]      s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // drive
  output logic [axcp_pkg::DRIVE_BITS-1:0]         m_axis_tdata,
  // loop_kind, clamped
  output logic [1:0]                              m_axis_tuser
);

  localparam int SB = SIGNAL_BITS;
  localparam int LB = axcp_pkg::LOAD_BITS;

  axcp_pkg::axcp_gains_t                 gains;
  logic [axcp_pkg::LIMIT_BITS-1:0]       limit;
  logic                                  op_valid, op_ready;
  logic signed [axcp_pkg::GAIN_BITS-1:0] gain_p, gain_i, gain_d;
  logic signed [SB:0]                    op_p;
  logic signed [INTEGRAL_BITS-1:0]       op_i;
  logic signed [SB+1:0]                  op_d;
  axcp_pkg::axcp_flags_t                 op_flags, out_flags;
  logic signed [axcp_pkg::DRIVE_BITS-1:0] drive;

  axcp_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .gains_o    (gains),
    .limit_o    (limit)
  );

  axcp_state #(
    .SIGNAL_BITS   (SIGNAL_BITS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .req_type_i       (s_axis_tuser),
    .setpoint_i       ($signed(s_axis_tdata[SB-1:0])),
    .measured_value_i ($signed(s_axis_tdata[2*SB-1:SB])),
    .gyro_rate_i      ($signed(s_axis_tdata[3*SB-1:2*SB])),
    .integral_load_i  ($signed(s_axis_tdata[3*SB+LB-1:3*SB])),
    .gains_i          (gains),
    .limit_i          (limit),
    .down_ready_i     (op_ready),
    .op_valid_o       (op_valid),
    .gain_p_o         (gain_p),
    .gain_i_o         (gain_i),
    .gain_d_o         (gain_d),
    .op_p_o           (op_p),
    .op_i_o           (op_i),
    .op_d_o           (op_d),
    .flags_o          (op_flags)
  );

  axcp_mac #(
    .SIGNAL_BITS   (SIGNAL_BITS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .gain_p_i    (gain_p),
    .gain_i_i    (gain_i),
    .gain_d_i    (gain_d),
    .op_p_i      (op_p),
    .op_i_i      (op_i),
    .op_d_i      (op_d),
    .flags_i     (op_flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .drive_o     (drive),
    .flags_o     (out_flags)
  );

  assign m_axis_tdata = drive;
  assign m_axis_tuser = out_flags;

  // input back-pressure only appears behind a waiting result beat
  a_ready_low_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result beat pending");

endmodule

`default_nettype wire

[tb/tb_axis_cascade_pid.sv]
// tb_axis_cascade_pid: self-checking bench for the cascaded angle/rate pid axis
// drives a directed table then random beats; results are checked against table
// values or a bench predictor of the integrals and drive; depends on axcp_pkg

module tb_axis_cascade_pid;
  import axcp_pkg::*;

  localparam int SIG_BITS   = 16;
  localparam int INTEG_BITS = 24;
  localparam int TDATA_W    = ((3*SIG_BITS + LOAD_BITS + 7) / 8) * 8;
  localparam int SETTLE     = 8;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES     = 9;
  localparam int PHASE_BEATS = 50;

  localparam logic [REQ_BITS-1:0]      REQ_UNUSED = 2'd3;
  localparam logic [REG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;

  localparam longint INTEG_MAX = (longint'(1) << (INTEG_BITS - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint DRIVE_MAX = longint'(32'h7FFF_FFFF);
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] drive;
    logic                  loop_kind;
    logic                  clamped;
  } drive_beat_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [REG_ADDR_BITS-1:0] addr;
    logic [LIMIT_BITS-1:0]  data;
    logic [REQ_BITS-1:0]    req;
    logic [SIG_BITS-1:0]    setpoint;
    logic [SIG_BITS-1:0]    measured;
    logic [SIG_BITS-1:0]    gyro;
    logic [LOAD_BITS-1:0]   load;
    bit                     typed;
    drive_beat_t            fixed;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [REG_ADDR_BITS-1:0] cfg_addr_i = '0;
  logic [LIMIT_BITS-1:0]    cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [TDATA_W-1:0]       s_axis_tdata = '0;
  logic [REQ_BITS-1:0]      s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [DRIVE_BITS-1:0]    m_axis_tdata;
  logic [1:0]               m_axis_tuser;

  // sideband travelling with each input beat
  logic        beat_typed = 1'b0;
  drive_beat_t beat_fixed = '0;

  // predictor state
  logic signed [GAIN_BITS-1:0] gain_q [6] = '{default: '0};
  logic [LIMIT_BITS-1:0]       limit_q = LIMIT_RESET;
  longint                      angle_acc = 0;
  longint                      rate_acc = 0;
  longint                      prev_rate_err = 0;

  drive_beat_t pending_drives[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_start = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_cnt = 0;

  stim_row_t directed[$];

  axis_cascade_pid #(
    .SIGNAL_BITS  (SIG_BITS),
    .INTEGRAL_BITS(INTEG_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint next_integral(input longint acc, input longint err,
                                           output logic hit);
    longint lim;
    longint s;
    lim = longint'(limit_q);
    if (lim > INTEG_MAX) lim = INTEG_MAX;
    s = acc + err;
    hit = 1'b0;
    if (s > lim) begin
      s = lim;
      hit = 1'b1;
    end
    if (s < INTEG_MIN) s = INTEG_MIN;
    return s;
  endfunction

  function automatic logic [DRIVE_BITS-1:0] saturate_drive(input longint v);
    if (v > DRIVE_MAX) v = DRIVE_MAX;
    if (v < DRIVE_MIN) v = DRIVE_MIN;
    return v[DRIVE_BITS-1:0];
  endfunction

  function automatic bit step_predictor(input logic [REQ_BITS-1:0] req,
                                        input logic [TDATA_W-1:0] pl,
                                        output drive_beat_t res);
    longint sp;
    longint meas;
    longint gyro;
    longint err;
    longint d;
    longint sum;
    logic   hit;
    sp   = longint'($signed(pl[SIG_BITS-1:0]));
    meas = longint'($signed(pl[2*SIG_BITS-1:SIG_BITS]));
    gyro = longint'($signed(pl[3*SIG_BITS-1:2*SIG_BITS]));
    res = '0;
    case (req)
      REQ_ANGLE: begin
        err = meas - sp;
        angle_acc = next_integral(angle_acc, err, hit);
        sum = longint'(gain_q[REG_ANGLE_KP]) * err
            - longint'(gain_q[REG_ANGLE_KI]) * angle_acc
            + longint'(gain_q[REG_ANGLE_KD]) * gyro;
        res.drive = saturate_drive(sum);
        res.loop_kind = 1'b0;
        res.clamped = hit;
        return 1'b1;
      end
      REQ_RATE: begin
        err = gyro - sp;
        d = err - prev_rate_err;
        rate_acc = next_integral(rate_acc, err, hit);
        prev_rate_err = err;
        sum = longint'(gain_q[REG_RATE_KP]) * err
            - longint'(gain_q[REG_RATE_KI]) * rate_acc
            + longint'(gain_q[REG_RATE_KD]) * d;
        res.drive = saturate_drive(sum);
        res.loop_kind = 1'b1;
        res.clamped = hit;
        return 1'b1;
      end
      REQ_LOAD: begin
        angle_acc = longint'($signed(pl[3*SIG_BITS+LOAD_BITS-1:3*SIG_BITS]));
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
    end
  endfunction

  // scoreboard and predictor, all at the rising edge
  always @(posedge clk_i) begin
    drive_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_drives.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, m_axis_tdata);
        end else begin
          want = pending_drives.pop_front();
          check_field("drive", want.drive, m_axis_tdata);
          check_field("loop_kind", want.loop_kind, m_axis_tuser[0]);
          check_field("clamped", want.clamped, m_axis_tuser[1]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (step_predictor(s_axis_tuser, s_axis_tdata, want))
          pending_drives.push_back(beat_typed ? beat_fixed : want);
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_LIMIT) limit_q = cfg_data_i;
        else if (cfg_addr_i <= REG_RATE_KD) gain_q[cfg_addr_i] = cfg_data_i[GAIN_BITS-1:0];
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_start != hold_ack) begin
      hold_ack <= hold_start;
      hold_cnt <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [SIG_BITS-1:0] pick_signal();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4, 5: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LOAD_BITS-1:0] pick_load();
    case ($urandom_range(4))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(8191)) - 24'd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_BITS-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return LIMIT_RESET;
      2: return 23'h7FFFFF;
      3: return 23'($urandom_range(4095));
      default: return 23'($urandom);
    endcase
  endfunction

  function automatic stim_row_t beat_row(input logic [REQ_BITS-1:0] req,
                                         input logic [SIG_BITS-1:0] sp, meas, gyro,
                                         input logic [LOAD_BITS-1:0] load);
    stim_row_t r;
    r = '{kind: ROW_BEAT, addr: '0, data: '0, req: req, setpoint: sp, measured: meas,
          gyro: gyro, load: load, typed: 1'b0, fixed: '0};
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input logic [REQ_BITS-1:0] req,
                                          input logic [SIG_BITS-1:0] sp, meas, gyro,
                                          input logic [DRIVE_BITS-1:0] drive,
                                          input logic clamped);
    stim_row_t r;
    r = beat_row(req, sp, meas, gyro, '0);
    r.typed = 1'b1;
    r.fixed = '{drive: drive, loop_kind: (req == REQ_RATE), clamped: clamped};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [REG_ADDR_BITS-1:0] addr,
                                        input logic [LIMIT_BITS-1:0] data);
    stim_row_t r;
    r = beat_row(REQ_ANGLE, '0, '0, '0, '0);
    r.kind = ROW_CFG;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  task automatic send_beat(input logic [REQ_BITS-1:0] req, input logic [TDATA_W-1:0] pl,
                           input bit typed, input drive_beat_t fixed);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= TDATA_W'({$urandom, $urandom, $urandom});
      s_axis_tuser  <= 2'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pl;
    s_axis_tuser  <= req;
    beat_typed    <= typed;
    beat_fixed    <= fixed;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random_beat(output bit counted);
    logic [REQ_BITS-1:0] req;
    int r;
    r = $urandom_range(99);
    req = (r < 42) ? REQ_ANGLE : (r < 84) ? REQ_RATE : (r < 96) ? REQ_LOAD : REQ_UNUSED;
    counted = (req != REQ_UNUSED);
    send_beat(req, TDATA_W'({pick_load(), pick_signal(), pick_signal(), pick_signal()}),
              1'b0, '0);
  endtask

  // let every expected beat arrive and any load step finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_drives.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_ADDR_BITS-1:0] addr,
                           input logic [LIMIT_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic randomize_config();
    for (int a = REG_ANGLE_KP; a <= REG_LIMIT; a++) begin
      if (a == REG_LIMIT) write_reg(3'(a), pick_limit());
      else write_reg(3'(a), {7'($urandom), pick_gain()});
    end
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 23'($urandom));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    bit cfg_open;
    bit counted;
    int n;

    // reset values: zero gains, limit of 1920
    directed.push_back(fixed_row(REQ_ANGLE, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0));
    directed.push_back(fixed_row(REQ_ANGLE, 16'h8000, 16'h7FFF, 16'h7FFF, 32'h0, 1'b1));
    directed.push_back(fixed_row(REQ_RATE,  16'h8000, 16'h0000, 16'h7FFF, 32'h0, 1'b1));
    directed.push_back(fixed_row(REQ_ANGLE, 16'h7FFF, 16'h8000, 16'h8000, 32'h0, 1'b0));
    directed.push_back(beat_row(REQ_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h800000));
    // integral floor, no clamp flag
    directed.push_back(fixed_row(REQ_ANGLE, 16'h7FFF, 16'h8000, 16'h0000, 32'h0, 1'b0));
    directed.push_back(beat_row(REQ_UNUSED, 16'h1234, 16'h5678, 16'h9ABC, 24'hFFFFFF));
    directed.push_back(fixed_row(REQ_RATE,  16'h7FFF, 16'h7FFF, 16'h8000, 32'h0, 1'b0));
    // zero limit: sum equal to bound is not clamped
    directed.push_back(cfg_row(REG_LIMIT, '0));
    directed.push_back(cfg_row(REG_UNUSED, 23'h7FFFFF));
    directed.push_back(beat_row(REQ_LOAD, 16'h0000, 16'h0000, 16'h0000, 24'h000000));
    directed.push_back(fixed_row(REQ_ANGLE, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0));
    directed.push_back(fixed_row(REQ_ANGLE, 16'h0000, 16'h0001, 16'h0000, 32'h0, 1'b1));
    // extreme gains, positive saturation
    directed.push_back(cfg_row(REG_ANGLE_KP, 23'h007FFF));
    directed.push_back(cfg_row(REG_ANGLE_KI, 23'h008000));
    directed.push_back(cfg_row(REG_ANGLE_KD, 23'h007FFF));
    directed.push_back(cfg_row(REG_LIMIT, 23'h7FFFFF));
    directed.push_back(beat_row(REQ_LOAD, 16'h0000, 16'h0000, 16'h0000, 24'h7FFFFF));
    directed.push_back(fixed_row(REQ_ANGLE, 16'h8000, 16'h7FFF, 16'h7FFF,
                                 32'h7FFF_FFFF, 1'b1));
    directed.push_back(beat_row(REQ_ANGLE, 16'h7FFF, 16'h8000, 16'h8000, 24'h800000));
    directed.push_back(cfg_row(REG_RATE_KP, {7'h7F, 16'h8000}));
    directed.push_back(cfg_row(REG_RATE_KI, 23'h007FFF));
    directed.push_back(cfg_row(REG_RATE_KD, {7'h55, 16'h8000}));
    directed.push_back(beat_row(REQ_RATE, 16'h8000, 16'h8000, 16'h7FFF, 24'h000000));
    directed.push_back(beat_row(REQ_RATE, 16'h7FFF, 16'h0000, 16'h8000, 24'h000000));
    directed.push_back(beat_row(REQ_RATE, 16'h0000, 16'h0000, 16'h0000, 24'h000000));
    // moderate gains, ignored fields carry noise
    directed.push_back(cfg_row(REG_ANGLE_KP, 23'h000100));
    directed.push_back(cfg_row(REG_ANGLE_KI, 23'h7F0010));
    directed.push_back(cfg_row(REG_ANGLE_KD, 23'h00FF00));
    directed.push_back(cfg_row(REG_RATE_KP, 23'h000080));
    directed.push_back(cfg_row(REG_RATE_KI, 23'h00FFF0));
    directed.push_back(cfg_row(REG_RATE_KD, 23'h000040));
    directed.push_back(cfg_row(REG_LIMIT, LIMIT_RESET));
    directed.push_back(beat_row(REQ_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h000200));
    directed.push_back(beat_row(REQ_ANGLE, 16'h0040, 16'h0100, 16'hFFC0, 24'hABCDEF));
    directed.push_back(beat_row(REQ_RATE, 16'hFF00, 16'h7FFF, 16'h0100, 24'h555555));
    directed.push_back(beat_row(REQ_RATE, 16'h0000, 16'h0000, 16'h0000, 24'h000000));
    directed.push_back(beat_row(REQ_ANGLE, 16'h0010, 16'hFFF0, 16'h0020, 24'h000000));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 35;
    rx_idle_pct <= 72;
    cfg_open = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (!cfg_open) wait_idle();
        write_reg(directed[i].addr, directed[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          @(negedge clk_i);
          cfg_open = 1'b0;
        end
        send_beat(directed[i].req,
                  TDATA_W'({directed[i].load, directed[i].gyro, directed[i].measured,
                            directed[i].setpoint}),
                  directed[i].typed, directed[i].fixed);
      end
    end
    if (cfg_open) begin
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      randomize_config();
      case (ph / 3)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct <= 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct <= 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      // long receiver hold-off while beats keep coming
      if (ph == 6) hold_start <= ~hold_start;
      n = 0;
      while (n < PHASE_BEATS) begin
        send_random_beat(counted);
        if (counted) begin
          n++;
          // sender pause until the pipeline drains
          if (ph == 7 && n == PHASE_BEATS / 2) wait_idle();
        end
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
